// File: sv/sspb_pkg.sv
package sspb_pkg;

   localparam int unsigned ADDR_W  = 22;
   localparam int unsigned COLOR_W = 32;
   localparam int unsigned SCALE_W = 4;
   localparam int unsigned LDIM_W  = 9;
   localparam int unsigned PITCH_W = 12;
   localparam int unsigned CSR_AW  = 4;
   localparam int unsigned CSR_DW  = 32;

   typedef struct packed {
      logic [7:0]         sprite_row;
      logic [7:0]         sprite_col;
      logic [3:0]         cell_row;
      logic [3:0]         cell_col;
      logic               cell_set;
      logic [COLOR_W-1:0] pixel_color;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  write_address;
      logic [COLOR_W-1:0] write_color;
      logic               out_of_range;
      logic               last_write;
   } rsp_type;

   typedef struct packed {
      logic [SCALE_W-1:0] scale_factor;
      logic [LDIM_W-1:0]  logical_width;
      logic [LDIM_W-1:0]  logical_height;
      logic [PITCH_W-1:0] line_pitch;
   } cfg_type;

   typedef enum logic [1:0] {
      REG_SCALE_FACTOR   = 2'd0,
      REG_LOGICAL_WIDTH  = 2'd1,
      REG_LOGICAL_HEIGHT = 2'd2,
      REG_LINE_PITCH     = 2'd3
   } reg_idx_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_BASE,
      ST_EMIT
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic scale;
      logic base;
      logic step;
      logic emit_oor;
   } ctrl_cmd_type;

   typedef struct packed {
      logic skip;
      logic oor;
      logic last;
   } dp_status_type;

endpackage

// File: sv/sspb_regs.sv
module sspb_regs (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [sspb_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [sspb_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [sspb_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                         csr_pready,
   output sspb_pkg::cfg_type            cfg
);
   import sspb_pkg::*;

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   reg_idx_type idx;
   logic        wr_en;

   assign idx        = reg_idx_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_SCALE_FACTOR:   cfg_in.scale_factor   = csr_pwdata[SCALE_W-1:0];
            REG_LOGICAL_WIDTH:  cfg_in.logical_width  = csr_pwdata[LDIM_W-1:0];
            REG_LOGICAL_HEIGHT: cfg_in.logical_height = csr_pwdata[LDIM_W-1:0];
            REG_LINE_PITCH:     cfg_in.line_pitch     = csr_pwdata[PITCH_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_SCALE_FACTOR:   csr_prdata = CSR_DW'(cfg_ff.scale_factor);
         REG_LOGICAL_WIDTH:  csr_prdata = CSR_DW'(cfg_ff.logical_width);
         REG_LOGICAL_HEIGHT: csr_prdata = CSR_DW'(cfg_ff.logical_height);
         REG_LINE_PITCH:     csr_prdata = CSR_DW'(cfg_ff.line_pitch);
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scale_factor   <= SCALE_W'(8);
         cfg_ff.logical_width  <= LDIM_W'(128);
         cfg_ff.logical_height <= LDIM_W'(128);
         cfg_ff.line_pitch     <= PITCH_W'(1024);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: sv/sspb_ctrl.sv
module sspb_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  sspb_pkg::dp_status_type status,
   output sspb_pkg::ctrl_cmd_type  cmd
);
   import sspb_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.skip) begin
               state_in = ST_IDLE;
            end else if (status.oor) begin
               cmd.emit_oor = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               cmd.scale = 1'b1;
               state_in  = ST_BASE;
            end
         end
         ST_BASE: begin
            cmd.base = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.step = 1'b1;
            if (status.last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// File: sv/sspb_dpath.sv
module sspb_dpath #(
   parameter int unsigned MAX_SCALE_FACTOR = 8,
   parameter int unsigned SPRITE_DIM       = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  sspb_pkg::req_type       req_data,
   input  sspb_pkg::cfg_type       cfg,
   input  sspb_pkg::ctrl_cmd_type  cmd,
   output sspb_pkg::dp_status_type status,
   output logic                    rsp_strobe,
   output sspb_pkg::rsp_type       rsp_data
);
   import sspb_pkg::*;

   localparam logic [6:0]         DimLim   = 7'(SPRITE_DIM);
   localparam logic [SCALE_W-1:0] ScaleMax = SCALE_W'(MAX_SCALE_FACTOR);

   req_type            req_ff;
   logic [LDIM_W-1:0]  lrow_ff, lcol_ff;
   logic [11:0]        row0_ff, col0_ff;
   logic [ADDR_W-1:0]  row_start_ff, addr_ff;
   logic [SCALE_W-1:0] i_ff, j_ff;
   rsp_type            rsp_ff, rsp_in;
   logic               strobe_ff;

   logic [SCALE_W-1:0] scale, scale_m1;
   logic [ADDR_W-1:0]  base, next_row;
   logic               row_end;

   // zero acts as one, anything above the maximum saturates
   always_comb begin
      scale = cfg.scale_factor;
      if (scale == '0) begin
         scale = SCALE_W'(1);
      end else if (scale > ScaleMax) begin
         scale = ScaleMax;
      end
   end

   assign scale_m1 = scale - SCALE_W'(1);
   assign row_end  = (j_ff == scale_m1);
   assign base     = ADDR_W'(row0_ff * cfg.line_pitch) + ADDR_W'(col0_ff);
   assign next_row = row_start_ff + ADDR_W'(cfg.line_pitch);

   assign status.skip = !req_ff.cell_set
                        || ({3'b000, req_ff.cell_row} >= DimLim)
                        || ({3'b000, req_ff.cell_col} >= DimLim);
   assign status.oor  = (lrow_ff >= cfg.logical_height)
                        || (lcol_ff >= cfg.logical_width);
   assign status.last = (i_ff == scale_m1) && row_end;

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.emit_oor) begin
         rsp_in              = '0;
         rsp_in.out_of_range = 1'b1;
         rsp_in.last_write   = 1'b1;
      end else if (cmd.step) begin
         rsp_in.write_address = addr_ff;
         rsp_in.write_color   = req_ff.pixel_color;
         rsp_in.out_of_range  = 1'b0;
         rsp_in.last_write    = status.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.step || cmd.emit_oor;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (cmd.load) begin
         req_ff  <= req_data;
         lrow_ff <= {1'b0, req_data.sprite_row} + LDIM_W'(req_data.cell_row);
         lcol_ff <= {1'b0, req_data.sprite_col} + LDIM_W'(req_data.cell_col);
      end
      if (cmd.scale) begin
         row0_ff <= 12'(lrow_ff * scale);
         col0_ff <= 12'(lcol_ff * scale);
      end
      if (cmd.base) begin
         row_start_ff <= base;
         addr_ff      <= base;
         i_ff         <= '0;
         j_ff         <= '0;
      end else if (cmd.step) begin
         // advance along the row, or drop to the start of the next screen row
         if (row_end) begin
            j_ff         <= '0;
            i_ff         <= i_ff + SCALE_W'(1);
            row_start_ff <= next_row;
            addr_ff      <= next_row;
         end else begin
            j_ff    <= j_ff + SCALE_W'(1);
            addr_ff <= addr_ff + ADDR_W'(1);
         end
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// File: sv/scaled_sprite_pixel_blitter.sv
// Scaled sprite pixel blitter.
// Input: drive one sprite cell on req_data and raise start; the cell is taken
// at a clock edge where start is high and busy is low.
// Output: each framebuffer write appears on rsp_data for one cycle, marked by
// rsp_strobe; the receiver must take it then. last_write marks the final beat
// of a cell. An off-screen cell gives one beat with out_of_range set.
// A clear cell, or one outside the sprite, gives no beat.
// Timing: a drawn cell passes through the states CHECK, BASE and EMIT and gives s*s
// beats, s being the effective scale (1..8). busy stays high from acceptance until the
// last beat has been stepped out; beats come one per cycle. A clear or off-screen cell
// returns to idle from CHECK. An address register walks the square, stepping along
// a row and moving down to the next screen row by line_pitch.
// Configuration: APB-style registers at 0x0 scale factor, 0x4 logical_width,
// 0x8 logical_height, 0xC line_pitch; write them only while busy is low.
// Reset returns the registers to 8, 128, 128, 1024 and the controller to idle.
module scaled_sprite_pixel_blitter #(
   parameter int unsigned MAX_SCALE_FACTOR = 8,
   parameter int unsigned SPRITE_DIM       = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  sspb_pkg::req_type            req_data,
   output logic                         rsp_strobe,
   output sspb_pkg::rsp_type            rsp_data,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [sspb_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [sspb_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [sspb_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                         csr_pready
);
   import sspb_pkg::*;

   cfg_type       cfg;
   ctrl_cmd_type  cmd;
   dp_status_type status;

   sspb_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sspb_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   sspb_dpath #(
      .MAX_SCALE_FACTOR (MAX_SCALE_FACTOR),
      .SPRITE_DIM       (SPRITE_DIM)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cfg        (cfg),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

// File: verif/sspb_write_checker.sv
module sspb_write_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  sspb_pkg::req_type             req_data,
   input  logic                          rsp_strobe,
   input  sspb_pkg::rsp_type             rsp_data,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [sspb_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [sspb_pkg::CSR_DW-1:0]   csr_pwdata,
   input  logic                          csr_pready,
   output int                            writes_due,
   output int                            mismatches
);
   timeunit 1ns;
   timeprecision 1ps;
   import sspb_pkg::*;

   localparam int unsigned MAX_SCALE = 8;

   cfg_type live_cfg;
   rsp_type pending_writes[$];
   int      errors = 0;

   // Expand one accepted cell into the square of framebuffer writes it should produce.
   function automatic void expand_cell(input req_type cur_cell);
      logic [8:0]  lrow;
      logic [8:0]  lcol;
      logic [31:0] addr;
      int unsigned s;
      int unsigned row;
      int unsigned col;
      rsp_type     w;
      if (!cur_cell.cell_set) return;
      lrow = cur_cell.sprite_row + cur_cell.cell_row;
      lcol = cur_cell.sprite_col + cur_cell.cell_col;
      if (lrow >= live_cfg.logical_height || lcol >= live_cfg.logical_width) begin
         w = '0;
         w.out_of_range = 1'b1;
         w.last_write = 1'b1;
         pending_writes.push_back(w);
         return;
      end
      s = live_cfg.scale_factor;
      if (s == 0) s = 1;
      if (s > MAX_SCALE) s = MAX_SCALE;
      for (int unsigned i = 0; i < s; i++) begin
         row = lrow * s + i;
         for (int unsigned j = 0; j < s; j++) begin
            col = lcol * s + j;
            addr = row * live_cfg.line_pitch + col;
            w.write_address = addr[ADDR_W-1:0];
            w.write_color = cur_cell.pixel_color;
            w.out_of_range = 1'b0;
            w.last_write = (i == s - 1 && j == s - 1);
            pending_writes.push_back(w);
         end
      end
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         live_cfg = '{scale_factor: 4'd8, logical_width: 9'd128, logical_height: 9'd128,
                      line_pitch: 12'd1024};
         pending_writes.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_idx_type'(csr_paddr[3:2]))
               REG_SCALE_FACTOR:   live_cfg.scale_factor = csr_pwdata[SCALE_W-1:0];
               REG_LOGICAL_WIDTH:  live_cfg.logical_width = csr_pwdata[LDIM_W-1:0];
               REG_LOGICAL_HEIGHT: live_cfg.logical_height = csr_pwdata[LDIM_W-1:0];
               REG_LINE_PITCH:     live_cfg.line_pitch = csr_pwdata[PITCH_W-1:0];
            endcase
         end
         if (start && !busy) expand_cell(req_data);
         if (rsp_strobe) begin
            if (pending_writes.size() == 0) begin
               $display({"%0t: unexpected write beat, expected none, actual addr 0x%0h",
                         " color 0x%0h oor %0b last %0b"},
                        $time, rsp_data.write_address, rsp_data.write_color,
                        rsp_data.out_of_range, rsp_data.last_write);
               errors++;
            end else begin
               want = pending_writes.pop_front();
               check_field("write_address", 32'(want.write_address),
                           32'(rsp_data.write_address));
               check_field("write_color", want.write_color, rsp_data.write_color);
               check_field("out_of_range", 32'(want.out_of_range),
                           32'(rsp_data.out_of_range));
               check_field("last_write", 32'(want.last_write), 32'(rsp_data.last_write));
            end
         end
      end
      writes_due <= pending_writes.size();
      mismatches <= errors;
   end

endmodule

// File: verif/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sspb_pkg::*;

   localparam int QUIET_LIMIT = 1000;
   localparam int SETTLE_TAIL = 8;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   req_type             req_data = '0;
   logic                rsp_strobe;
   rsp_type             rsp_data;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr = '0;
   logic [CSR_DW-1:0]   csr_pwdata = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;
   int                  writes_due;
   int                  mismatches;
   int                  quiet_cycles = 0;

   scaled_sprite_pixel_blitter uut (.*);
   sspb_write_checker write_check (.*);

   always #5 clock = ~clock;

   // Count cycles with no beat on any channel.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   function automatic req_type make_cell(input int srow, input int scol, input int crow,
                                         input int ccol, input bit set,
                                         input logic [31:0] color);
      req_type c;
      c.sprite_row = 8'(srow);
      c.sprite_col = 8'(scol);
      c.cell_row = 4'(crow);
      c.cell_col = 4'(ccol);
      c.cell_set = set;
      c.pixel_color = color;
      return c;
   endfunction

   // Mostly land on screen under the given settings; the rest is anywhere.
   function automatic req_type random_cell(input cfg_type cfg);
      req_type     c;
      int unsigned rmax;
      int unsigned cmax;
      c.pixel_color = $urandom;
      c.cell_set = ($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 9) < 7) begin
         rmax = (cfg.logical_height > 256) ? 255 :
                (cfg.logical_height == 0) ? 0 : cfg.logical_height - 1;
         cmax = (cfg.logical_width > 256) ? 255 :
                (cfg.logical_width == 0) ? 0 : cfg.logical_width - 1;
         c.sprite_row = 8'($urandom_range(0, rmax));
         c.sprite_col = 8'($urandom_range(0, cmax));
         c.cell_row = 4'($urandom_range(0, (rmax - c.sprite_row > 15) ? 15 :
                                           rmax - c.sprite_row));
         c.cell_col = 4'($urandom_range(0, (cmax - c.sprite_col > 15) ? 15 :
                                           cmax - c.sprite_col));
      end else begin
         c.sprite_row = 8'($urandom);
         c.sprite_col = 8'($urandom);
         c.cell_row = 4'($urandom);
         c.cell_col = 4'($urandom);
      end
      return c;
   endfunction

   // Hold start high until the block takes the cell.
   task automatic issue_cell(input req_type cur_cell);
      start <= 1'b1;
      req_data <= cur_cell;
      do @(posedge clock); while (busy);
   endtask

   task automatic run_cells(input cfg_type cfg, input int count);
      int left;
      int burst;
      int gap;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 8);
         for (int k = 0; k < burst && left > 0; k++) begin
            issue_cell(random_cell(cfg));
            left--;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Drop start and wait until every expected write has come and the block is idle.
   task automatic settle();
      start <= 1'b0;
      repeat (2) @(posedge clock);
      while (writes_due != 0 || busy) @(posedge clock);
      repeat (SETTLE_TAIL) @(posedge clock);
   endtask

   // psel stays high across back-to-back writes; the caller drops it.
   task automatic csr_write(input reg_idx_type idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   task automatic apply_settings(input cfg_type cfg);
      csr_write(REG_SCALE_FACTOR, 32'(cfg.scale_factor));
      csr_write(REG_LOGICAL_WIDTH, 32'(cfg.logical_width));
      csr_write(REG_LOGICAL_HEIGHT, 32'(cfg.logical_height));
      csr_write(REG_LINE_PITCH, 32'(cfg.line_pitch));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   initial begin
      cfg_type fixed_cfgs[5];
      int      fixed_counts[5];
      cfg_type cfg;
      // scale zero with pitch zero, saturated scale with address wrap, one-pixel screen,
      // zero-size screen, odd sizes with unit pitch
      fixed_cfgs = '{'{4'd0, 9'd256, 9'd256, 12'd0},
                     '{4'd15, 9'd511, 9'd511, 12'd4095},
                     '{4'd1, 9'd1, 9'd1, 12'd1},
                     '{4'd2, 9'd0, 9'd0, 12'd2048},
                     '{4'd3, 9'd200, 9'd40, 12'd1}};
      fixed_counts = '{25, 25, 20, 10, 20};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // registers at their reset values: corners, edges of the screen, clear and off-screen cells
      issue_cell(make_cell(0, 0, 0, 0, 1, 32'h0000_0000));
      issue_cell(make_cell(0, 0, 0, 0, 1, 32'hFFFF_FFFF));
      issue_cell(make_cell(0, 0, 0, 0, 0, 32'h1234_5678));
      issue_cell(make_cell(112, 112, 15, 15, 1, 32'hA5A5_A5A5));
      issue_cell(make_cell(113, 0, 15, 0, 1, 32'h5A5A_5A5A));
      issue_cell(make_cell(0, 113, 0, 15, 1, 32'hDEAD_BEEF));
      issue_cell(make_cell(0, 127, 0, 0, 1, 32'h0F0F_0F0F));
      issue_cell(make_cell(255, 255, 15, 15, 1, 32'hFFFF_FFFF));
      issue_cell(make_cell(255, 255, 15, 15, 0, 32'hFFFF_FFFF));
      issue_cell(make_cell(127, 0, 0, 0, 1, 32'hF0F0_F0F0));
      issue_cell(make_cell(0, 0, 15, 15, 0, 32'h0000_0001));
      issue_cell(make_cell(5, 9, 3, 10, 1, 32'h8000_0000));
      issue_cell(make_cell(128, 0, 0, 0, 1, 32'h7FFF_FFFF));
      settle();

      foreach (fixed_cfgs[p]) begin
         apply_settings(fixed_cfgs[p]);
         run_cells(fixed_cfgs[p], fixed_counts[p]);
         settle();
      end

      repeat (5) begin
         cfg.scale_factor = SCALE_W'($urandom_range(0, 15));
         cfg.logical_width = LDIM_W'($urandom_range(0, 511));
         cfg.logical_height = LDIM_W'($urandom_range(0, 511));
         cfg.line_pitch = PITCH_W'($urandom_range(0, 4095));
         apply_settings(cfg);
         run_cells(cfg, 22);
         settle();
      end

      if (mismatches == 0 && writes_due == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
